// ===== rtl/imufc_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte update for the IMU frame checker.
// No dependencies; every other file imports this package.
package imufc_pkg;

  localparam int SAMPLE_DEPTH = 21;
  localparam int SLOT_W       = $clog2(SAMPLE_DEPTH);

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd6;
  localparam logic [6:0]  COUNT_MAX      = 7'd127;

  // input commands
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_LINE_ERR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_FORWARDED   = 3'd0;
  localparam logic [2:0] ST_SIZE        = 3'd1;
  localparam logic [2:0] ST_HEADER      = 3'd2;
  localparam logic [2:0] ST_LENGTH      = 3'd3;
  localparam logic [2:0] ST_CRC         = 3'd4;
  localparam logic [2:0] ST_TAG         = 3'd5;
  localparam logic [2:0] ST_RATE        = 3'd6;
  localparam logic [2:0] ST_TX_REFUSED  = 3'd7;

  // configuration register indexes
  localparam logic [7:0] REG_PERIOD_TICKS = 8'd0;
  localparam logic [7:0] REG_SOF_FIRST    = 8'd1;
  localparam logic [7:0] REG_SOF_SECOND   = 8'd2;
  localparam logic [7:0] REG_PAYLOAD_TAG  = 8'd3;

  // frame index -> capture slot
  localparam logic [6:0] IDX_TEMP      = 7'd9;
  localparam logic [6:0] IDX_IMU_LO    = 7'd16;
  localparam logic [6:0] IDX_IMU_HI    = 7'd27;
  localparam logic [6:0] IDX_QUAT_LO   = 7'd46;
  localparam logic [6:0] IDX_QUAT_HI   = 7'd53;
  localparam logic [6:0] IMU_OFFSET    = 7'd15;
  localparam logic [6:0] QUAT_OFFSET   = 7'd33;

  typedef logic [SAMPLE_DEPTH-1:0][7:0] sample_arr_t;

  typedef struct packed {
    logic              clr;
    logic              wr;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } cap_req_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/imufc_if.sv =====
// Valid/ready channel interfaces for the IMU frame checker: input, result and config.
// Depends on imufc_pkg.
interface imufc_in_if;
  import imufc_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       tx_accepted;
  modport source (output valid, command, data_byte, last_byte, tx_accepted, input ready);
  modport sink   (input valid, command, data_byte, last_byte, tx_accepted, output ready);
endinterface

interface imufc_out_if;
  import imufc_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] quat_0;
  logic signed [15:0] quat_1;
  logic signed [15:0] quat_2;
  logic signed [15:0] quat_3;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [7:0]  temperature;
  modport source (output valid, status, quat_0, quat_1, quat_2, quat_3, accel_x, accel_y,
                  accel_z, gyro_x, gyro_y, gyro_z, temperature, input ready);
  modport sink   (input valid, status, quat_0, quat_1, quat_2, quat_3, accel_x, accel_y,
                  accel_z, gyro_x, gyro_y, gyro_z, temperature, output ready);
endinterface

interface imufc_cfg_if;
  import imufc_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/imufc_capture.sv =====
// Sample capture store: 21 bytes taken at fixed frame offsets, cleared on line error.
// Depends on imufc_pkg. Presents the post-write view for same-cycle result assembly.
module imufc_capture (
  input  logic                   clk,
  input  logic                   rst_n,
  input  imufc_pkg::cap_req_t    req,
  output imufc_pkg::sample_arr_t sample_nxt
);
  import imufc_pkg::*;

  sample_arr_t sample_r;

  always_comb begin
    sample_nxt = sample_r;
    if (req.clr) begin
      sample_nxt = '0;
    end else if (req.wr) begin
      sample_nxt[req.slot] = req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

endmodule

// ===== rtl/imu_frame_checker_rate_limiter_core.sv =====
// IMU frame checker with rate limiter: top level.
// A result word is registered: it is valid in the cycle after its last frame byte is accepted.
// Throughput: 1 input word per cycle; the frame state, CRC and capture update in one pass.
// The only stall is a held result: input is taken while the result register is empty
// or being drained. Synchronous active-low reset restores the register defaults, clears
// the frame state and capture bytes and sets the tick counter to 255 (saturated).
module imu_frame_checker_rate_limiter_core #(
  parameter int MAX_FRAME_BYTES = 82
) (
  input  logic     clk,
  input  logic     rst_n,
  imufc_in_if.sink    in_ch,
  imufc_out_if.source out_ch,
  imufc_cfg_if.sink   cfg_ch
);
  import imufc_pkg::*;

  localparam logic [7:0] MAX_SIZE = 8'(MAX_FRAME_BYTES);
  localparam logic [7:0] MIN_SIZE = FRAME_OVERHEAD + 8'd1;

  // configuration registers
  logic [7:0] period_ticks_r, sof_first_r, sof_second_r, payload_tag_r;

  // frame state
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [15:0] crc_running_r, crc_running_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic [15:0] length_field_r, length_field_nxt;
  logic [15:0] crc_received_r, crc_received_nxt;
  logic [7:0]  tag_seen_r, tag_seen_nxt;
  logic [7:0]  elapsed_ticks_r, elapsed_ticks_nxt;

  // result register
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] quat_r [4];
  logic [15:0] accel_r [3];
  logic [15:0] gyro_r [3];
  logic [7:0]  temp_r;

  logic        in_fire, is_byte, is_last, emit;
  logic [6:0]  idx;
  logic [7:0]  size;
  logic        show_sample;
  cap_req_t    cap_req;
  sample_arr_t sample_nxt;

  // input taken whenever the result register is free or draining this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_byte     = in_fire && (in_ch.command == CMD_BYTE);
  assign is_last     = in_ch.last_byte;
  assign emit        = is_byte && is_last;
  assign idx         = byte_count_r;
  assign size        = {1'b0, idx} + 8'd1;

  // capture slot decode
  always_comb begin
    cap_req.clr  = in_fire && (in_ch.command == CMD_LINE_ERR);
    cap_req.wr   = 1'b0;
    cap_req.slot = '0;
    cap_req.data = in_ch.data_byte;
    if (is_byte) begin
      if (idx == IDX_TEMP) begin
        cap_req.wr = 1'b1;
      end else if (idx >= IDX_IMU_LO && idx <= IDX_IMU_HI) begin
        cap_req.wr   = 1'b1;
        cap_req.slot = SLOT_W'(idx - IMU_OFFSET);
      end else if (idx >= IDX_QUAT_LO && idx <= IDX_QUAT_HI) begin
        cap_req.wr   = 1'b1;
        cap_req.slot = SLOT_W'(idx - QUAT_OFFSET);
      end
    end
  end

  imufc_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (cap_req),
    .sample_nxt (sample_nxt)
  );

  // frame parsing, checks and rate limit
  always_comb begin
    byte_count_nxt    = byte_count_r;
    crc_running_nxt   = crc_running_r;
    start_ok_nxt      = start_ok_r;
    length_field_nxt  = length_field_r;
    crc_received_nxt  = crc_received_r;
    tag_seen_nxt      = tag_seen_r;
    elapsed_ticks_nxt = elapsed_ticks_r;
    status_nxt        = ST_SIZE;

    if (in_fire && in_ch.command == CMD_TICK) begin
      if (elapsed_ticks_r != 8'hFF) begin
        elapsed_ticks_nxt = elapsed_ticks_r + 8'd1;
      end
    end

    if (is_byte) begin
      // header fields land by position
      if (idx == 7'd0) begin
        start_ok_nxt = (in_ch.data_byte == sof_first_r);
      end else if (idx == 7'd1) begin
        start_ok_nxt = start_ok_r && (in_ch.data_byte == sof_second_r);
      end else if (idx == 7'd2) begin
        length_field_nxt[7:0] = in_ch.data_byte;
      end else if (idx == 7'd3) begin
        length_field_nxt[15:8] = in_ch.data_byte;
      end else if (idx == 7'd4) begin
        crc_received_nxt[7:0] = in_ch.data_byte;
      end else if (idx == 7'd5) begin
        crc_received_nxt[15:8] = in_ch.data_byte;
      end else if (idx == 7'd6) begin
        tag_seen_nxt = in_ch.data_byte;
      end
      // CRC skips the two CRC bytes themselves
      if (idx != 7'd4 && idx != 7'd5) begin
        crc_running_nxt = crc16_byte(crc_running_r, in_ch.data_byte);
      end
      if (byte_count_r < COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 7'd1;
      end

      if (is_last) begin
        if (size < MIN_SIZE || size > MAX_SIZE) begin
          status_nxt = ST_SIZE;
        end else if (!start_ok_nxt) begin
          status_nxt = ST_HEADER;
        end else if (({1'b0, length_field_nxt} + 17'(FRAME_OVERHEAD)) != 17'(size)) begin
          status_nxt = ST_LENGTH;
        end else if (crc_running_nxt != crc_received_nxt) begin
          status_nxt = ST_CRC;
        end else if (tag_seen_nxt != payload_tag_r) begin
          status_nxt = ST_TAG;
        end else if (elapsed_ticks_r < period_ticks_r) begin
          status_nxt = ST_RATE;
        end else if (in_ch.tx_accepted) begin
          status_nxt        = ST_FORWARDED;
          elapsed_ticks_nxt = 8'd0;
        end else begin
          status_nxt = ST_TX_REFUSED;
        end
      end
    end

    // end of frame or line error: frame state back to defaults
    if (emit || cap_req.clr) begin
      byte_count_nxt   = '0;
      crc_running_nxt  = '0;
      start_ok_nxt     = 1'b1;
      length_field_nxt = '0;
      crc_received_nxt = '0;
      tag_seen_nxt     = '0;
    end
  end

  assign show_sample = (status_nxt == ST_FORWARDED) || (status_nxt == ST_TX_REFUSED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r  <= 8'd3;
      sof_first_r     <= 8'h5A;
      sof_second_r    <= 8'hA5;
      payload_tag_r   <= 8'h92;
      byte_count_r    <= '0;
      crc_running_r   <= '0;
      start_ok_r      <= 1'b1;
      length_field_r  <= '0;
      crc_received_r  <= '0;
      tag_seen_r      <= '0;
      elapsed_ticks_r <= 8'hFF;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_PERIOD_TICKS: period_ticks_r <= cfg_ch.data;
          REG_SOF_FIRST:    sof_first_r    <= cfg_ch.data;
          REG_SOF_SECOND:   sof_second_r   <= cfg_ch.data;
          REG_PAYLOAD_TAG:  payload_tag_r  <= cfg_ch.data;
          default: ;
        endcase
      end
      byte_count_r    <= byte_count_nxt;
      crc_running_r   <= crc_running_nxt;
      start_ok_r      <= start_ok_nxt;
      length_field_r  <= length_field_nxt;
      crc_received_r  <= crc_received_nxt;
      tag_seen_r      <= tag_seen_nxt;
      elapsed_ticks_r <= elapsed_ticks_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; sample fields zeroed unless the frame passed all checks
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= status_nxt;
      for (int q = 0; q < 4; q++) begin
        quat_r[q] <= show_sample ? {sample_nxt[13 + 2*q + 1], sample_nxt[13 + 2*q]} : 16'd0;
      end
      for (int a = 0; a < 3; a++) begin
        accel_r[a] <= show_sample ? {sample_nxt[7 + 2*a + 1], sample_nxt[7 + 2*a]} : 16'd0;
        gyro_r[a]  <= show_sample ? {sample_nxt[1 + 2*a + 1], sample_nxt[1 + 2*a]} : 16'd0;
      end
      temp_r <= show_sample ? sample_nxt[0] : 8'd0;
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.quat_0      = quat_r[0];
  assign out_ch.quat_1      = quat_r[1];
  assign out_ch.quat_2      = quat_r[2];
  assign out_ch.quat_3      = quat_r[3];
  assign out_ch.accel_x     = accel_r[0];
  assign out_ch.accel_y     = accel_r[1];
  assign out_ch.accel_z     = accel_r[2];
  assign out_ch.gyro_x      = gyro_r[0];
  assign out_ch.gyro_y      = gyro_r[1];
  assign out_ch.gyro_z      = gyro_r[2];
  assign out_ch.temperature = temp_r;

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_ch.valid)
    else $error("last byte accepted without a result");

  a_result_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(emit))
    else $error("result appeared without a last byte");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit || cap_req.clr) |=> (byte_count_r == 7'd0) && start_ok_r && (crc_running_r == 16'd0))
    else $error("frame state not restarted");

  a_forward_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && status_nxt == ST_FORWARDED) |=> (elapsed_ticks_r == 8'd0))
    else $error("tick counter not cleared on forward");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for imu_frame_checker_rate_limiter_core: frame checks, capture and rate limit.
// Depends on imufc_pkg and the channel interfaces in imufc_if; predicts every status word in-line.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imufc_pkg::*;

  localparam int FRAME_MAX     = 82;    // frame size limit given to the block
  localparam int HDR_BYTES     = 6;     // start bytes, length and CRC ahead of the payload
  localparam int SETTLE_CYCLES = 4;     // the block registers its result; leave margin for it to settle
  localparam int STALL_LIMIT   = 4000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES   = 300;   // long result-side hold-off in the pressure test

  localparam logic [1:0] CMD_UNUSED = 2'd3;  // command code the block must ignore

  localparam logic [7:0] DEF_PERIOD = 8'd3;
  localparam logic [7:0] DEF_SOF1   = 8'd90;
  localparam logic [7:0] DEF_SOF2   = 8'd165;
  localparam logic [7:0] DEF_TAG    = 8'd146;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] quat_0;
    logic signed [15:0] quat_1;
    logic signed [15:0] quat_2;
    logic signed [15:0] quat_3;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [7:0]  temperature;
  } imu_report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  imufc_in_if  in_ch();
  imufc_out_if out_ch();
  imufc_cfg_if cfg_ch();

  imu_frame_checker_rate_limiter_core #(.MAX_FRAME_BYTES(FRAME_MAX)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Shared run state
  int error_count  = 0;
  int words_sent   = 0;   // accepted words that the block acts on (unused command not counted)
  int frames_sent  = 0;
  bit steady       = 1'b0; // when set, neither side inserts idle cycles
  int hold_request = 0;    // result-side hold-off, counted down by the sink
  int sink_wait    = 0;
  int quiet_cycles = 0;

  // Mirror of the block: register copies and frame state
  logic [7:0]  period_reg, sof1_reg, sof2_reg, tag_reg;
  logic [6:0]  byte_idx;
  logic [15:0] crc_acc;
  logic        start_good;
  logic [15:0] len_field;
  logic [15:0] crc_rx;
  logic [7:0]  tag_byte;
  logic [7:0]  capture [SAMPLE_DEPTH];
  logic [7:0]  ticks_elapsed;

  imu_report_t expected_reports[$];

  // CRC-16/XMODEM, one bit at a time, MSB of the byte first
  function automatic logic [15:0] xmodem_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Frame byte 9 is the temperature, 16..27 gyro and accel, 46..53 the quaternion
  function automatic int capture_slot(logic [6:0] idx);
    if (idx == 7'd9) return 0;
    if (idx >= 7'd16 && idx <= 7'd27) return int'(idx) - 15;
    if (idx >= 7'd46 && idx <= 7'd53) return int'(idx) - 33;
    return -1;
  endfunction

  function automatic logic [15:0] le_pair(int slot);
    return {capture[slot + 1], capture[slot]};
  endfunction

  function automatic void frame_restart();
    byte_idx   = '0;
    crc_acc    = '0;
    start_good = 1'b1;
    len_field  = '0;
    crc_rx     = '0;
    tag_byte   = '0;
  endfunction

  function automatic void model_reset();
    period_reg = DEF_PERIOD;
    sof1_reg   = DEF_SOF1;
    sof2_reg   = DEF_SOF2;
    tag_reg    = DEF_TAG;
    frame_restart();
    foreach (capture[k]) capture[k] = 8'h00;
    ticks_elapsed = 8'd255;
  endfunction

  function automatic void apply_register(logic [7:0] idx, logic [7:0] v);
    case (idx)
      REG_PERIOD_TICKS: period_reg = v;
      REG_SOF_FIRST:    sof1_reg   = v;
      REG_SOF_SECOND:   sof2_reg   = v;
      REG_PAYLOAD_TAG:  tag_reg    = v;
      default: ;
    endcase
  endfunction

  // Advance the mirror by one accepted word; a closing byte queues one status word
  function automatic void predict_word(logic [1:0] cmd, logic [7:0] b, logic last, logic acc);
    int          slot;
    int          size;
    logic [2:0]  st;
    imu_report_t rep;
    if (cmd == CMD_TICK) begin
      if (ticks_elapsed != 8'd255) ticks_elapsed = ticks_elapsed + 8'd1;
    end else if (cmd == CMD_LINE_ERR) begin
      foreach (capture[k]) capture[k] = 8'h00;
      frame_restart();
    end else if (cmd == CMD_BYTE) begin
      case (byte_idx)
        7'd0: start_good = (b == sof1_reg);
        7'd1: start_good = start_good && (b == sof2_reg);
        7'd2: len_field[7:0]  = b;
        7'd3: len_field[15:8] = b;
        7'd4: crc_rx[7:0]     = b;
        7'd5: crc_rx[15:8]    = b;
        7'd6: tag_byte        = b;
        default: ;
      endcase
      // the received CRC bytes are left out of the running CRC
      if (byte_idx != 7'd4 && byte_idx != 7'd5) crc_acc = xmodem_step(crc_acc, b);
      slot = capture_slot(byte_idx);
      if (slot >= 0) capture[slot] = b;
      size = int'(byte_idx) + 1;
      if (byte_idx != 7'd127) byte_idx = byte_idx + 7'd1;
      if (last) begin
        if (size < HDR_BYTES + 1 || size > FRAME_MAX) st = ST_SIZE;
        else if (!start_good) st = ST_HEADER;
        else if (int'(len_field) + HDR_BYTES != size) st = ST_LENGTH;
        else if (crc_acc != crc_rx) st = ST_CRC;
        else if (tag_byte != tag_reg) st = ST_TAG;
        else if (ticks_elapsed < period_reg) st = ST_RATE;
        else if (acc) begin
          st = ST_FORWARDED;
          ticks_elapsed = 8'd0;
        end else st = ST_TX_REFUSED;
        rep = '0;
        rep.status = st;
        // samples go out only for frames that passed every check; stale bytes included
        if (st == ST_FORWARDED || st == ST_TX_REFUSED) begin
          rep.quat_0      = le_pair(13);
          rep.quat_1      = le_pair(15);
          rep.quat_2      = le_pair(17);
          rep.quat_3      = le_pair(19);
          rep.accel_x     = le_pair(7);
          rep.accel_y     = le_pair(9);
          rep.accel_z     = le_pair(11);
          rep.gyro_x      = le_pair(1);
          rep.gyro_y      = le_pair(3);
          rep.gyro_z      = le_pair(5);
          rep.temperature = capture[0];
        end
        expected_reports.push_back(rep);
        frame_restart();
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
      error_count++;
    end
  endfunction

  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Register writes, input words and result words are all handled in one block so
  // that a prediction is always in place before a same-edge result could be checked.
  always @(posedge clk) begin : scoreboard
    imu_report_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        predict_word(in_ch.command, in_ch.data_byte, in_ch.last_byte, in_ch.tx_accepted);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("status word %0d arrived with no frame end pending", out_ch.status);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 16'(want.status), 16'(out_ch.status));
          check_field("quat_0", want.quat_0, out_ch.quat_0);
          check_field("quat_1", want.quat_1, out_ch.quat_1);
          check_field("quat_2", want.quat_2, out_ch.quat_2);
          check_field("quat_3", want.quat_3, out_ch.quat_3);
          check_field("accel_x", want.accel_x, out_ch.accel_x);
          check_field("accel_y", want.accel_y, out_ch.accel_y);
          check_field("accel_z", want.accel_z, out_ch.accel_z);
          check_field("gyro_x", want.gyro_x, out_ch.gyro_x);
          check_field("gyro_y", want.gyro_y, out_ch.gyro_y);
          check_field("gyro_z", want.gyro_z, out_ch.gyro_z);
          check_field("temperature", 16'(want.temperature), 16'(out_ch.temperature));
        end
      end
    end
  end

  // Result side: after each taken word draw a stall that counts only while a word
  // is offered; a hold request overrides it and keeps ready low for that many cycles.
  always @(posedge clk) begin : result_sink
    if (hold_request > 0) begin
      hold_request--;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sink_wait = draw_wait();
      else if (out_ch.valid && sink_wait > 0) sink_wait--;
      out_ch.ready <= (sink_wait == 0);
    end
  end

  // Any handshake restarts the count; a long silence means the block is hung
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Offer one input word after a random gap and wait for it to be taken.
  // Called at a rising edge; valid stays high into the next word when there is no gap.
  task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic last, logic acc);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.data_byte   <= b;
    in_ch.last_byte   <= last;
    in_ch.tx_accepted <= acc;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Send a frame byte by byte; ticks and ignored words may slip in between bytes
  task automatic send_frame(byte_q_t fr, logic acc);
    int n;
    n = fr.size();
    foreach (fr[i]) begin
      if ($urandom_range(0, 23) == 0) send_tick();
      if ($urandom_range(0, 63) == 0)
        send_word(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
      send_word(CMD_BYTE, fr[i], i == n - 1, (i == n - 1) ? acc : 1'($urandom));
    end
    frames_sent++;
  endtask

  // Well-formed frame: start bytes, LE length, LE CRC, then tag and random payload
  function automatic byte_q_t make_frame(int pay_len, logic [7:0] first, logic [7:0] second,
                                         logic [7:0] tag);
    byte_q_t     fr;
    logic [15:0] crc;
    fr = {first, second, pay_len[7:0], pay_len[15:8], 8'h00, 8'h00};
    fr.push_back(tag);
    for (int i = 1; i < pay_len; i++) fr.push_back(8'($urandom));
    crc = 16'h0000;
    foreach (fr[i]) if (i != 4 && i != 5) crc = xmodem_step(crc, fr[i]);
    fr[4] = crc[7:0];
    fr[5] = crc[15:8];
    return fr;
  endfunction

  function automatic byte_q_t random_bytes(int n);
    byte_q_t fr;
    for (int i = 0; i < n; i++) fr.push_back(8'($urandom));
    return fr;
  endfunction

  // Hold the input, let every pending status word arrive, then let the pipe settle.
  // A clock edge is awaited first so the prediction for the word just taken is already queued.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [7:0] idx, logic [7:0] v);
    wait_results_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_registers(logic [7:0] period, logic [7:0] sof1, logic [7:0] sof2,
                                   logic [7:0] tag);
    write_register(REG_PERIOD_TICKS, period);
    write_register(REG_SOF_FIRST, sof1);
    write_register(REG_SOF_SECOND, sof2);
    write_register(REG_PAYLOAD_TAG, tag);
  endtask

  // One frame of random kind: mostly clean, the rest corrupted in one field, too short, oversize or random
  task automatic send_random_frame();
    byte_q_t    fr;
    byte_q_t    partial;
    int         kind;
    int         pay_len;
    int         cut;
    logic [7:0] flip;
    logic       acc;
    flip    = 8'($urandom_range(1, 255));
    acc     = ($urandom_range(0, 3) != 0);
    pay_len = ($urandom_range(0, 9) < 7) ? $urandom_range(48, FRAME_MAX - HDR_BYTES)
                                         : $urandom_range(1, 47);
    repeat ($urandom_range(0, 4)) send_tick();
    // now and then a frame is cut short by a line error
    if ($urandom_range(0, 29) == 0) begin
      partial = make_frame(pay_len, sof1_reg, sof2_reg, tag_reg);
      cut = $urandom_range(1, partial.size() - 1);
      for (int i = 0; i < cut; i++) send_word(CMD_BYTE, partial[i], 1'b0, 1'($urandom));
      send_word(CMD_LINE_ERR, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      fr = make_frame(pay_len, sof1_reg, sof2_reg, (kind >= 82) ? tag_reg ^ flip : tag_reg);
      if (kind >= 60 && kind < 65) fr[0] = fr[0] ^ flip;
      else if (kind >= 65 && kind < 70) fr[1] = fr[1] ^ flip;
      else if (kind >= 70 && kind < 76) fr[$urandom_range(2, 3)] ^= flip;
      else if (kind >= 76 && kind < 79) fr[$urandom_range(4, 5)] ^= flip;
      else if (kind >= 79 && kind < 82) fr[$urandom_range(6, fr.size() - 1)] ^= flip;
    end else if (kind < 92) begin
      fr = random_bytes($urandom_range(1, HDR_BYTES));
    end else if (kind < 96) begin
      // oversize frames, some long enough to saturate the byte counter
      fr = make_frame($urandom_range(FRAME_MAX - HDR_BYTES + 1, 134), sof1_reg, sof2_reg,
                      tag_reg);
    end else begin
      fr = random_bytes($urandom_range(1, 90));
    end
    send_frame(fr, acc);
  endtask

  task automatic test_random_traffic(int word_budget, int frame_budget);
    int first_word;
    int first_frame;
    first_word  = words_sent;
    first_frame = frames_sent;
    while (words_sent - first_word < word_budget || frames_sent - first_frame < frame_budget)
    begin
      steady = ($urandom_range(0, 7) == 0);
      send_random_frame();
    end
    steady = 1'b0;
  endtask

  // Every status code with minimum-size frames under the reset register values
  task automatic test_status_codes();
    byte_q_t fr;
    fr = {8'h00, 8'hFF};
    send_frame(fr, 1'b1);                                   // too short
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b1);                                   // forwarded, samples still zero
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b1);                                   // rate limited right after
    repeat (3) send_tick();
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b0);                                   // downstream refuses
    fr = make_frame(1, ~sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b1);                                   // bad first start byte
    fr = make_frame(1, sof1_reg, ~sof2_reg, tag_reg);
    send_frame(fr, 1'b1);                                   // bad second start byte
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    fr[2] = fr[2] ^ 8'h01;
    send_frame(fr, 1'b1);                                   // length field off by one
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    fr[4] = fr[4] ^ 8'h80;
    send_frame(fr, 1'b1);                                   // CRC mismatch
    fr = make_frame(1, sof1_reg, sof2_reg, ~tag_reg);
    send_frame(fr, 1'b1);                                   // wrong payload tag
  endtask

  // Line error mid-frame clears the captured samples; the unused command does nothing
  task automatic test_line_error();
    byte_q_t fr;
    repeat (3) send_tick();
    fr = make_frame(60, sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b1);
    fr = make_frame(60, sof1_reg, sof2_reg, tag_reg);
    for (int i = 0; i < 35; i++) send_word(CMD_BYTE, fr[i], 1'b0, 1'b0);
    send_word(CMD_LINE_ERR, 8'hFF, 1'b1, 1'b1);
    send_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
    repeat (3) send_word(CMD_TICK, 8'h00, 1'b1, 1'b1);
    fr = make_frame(1, sof1_reg, sof2_reg, tag_reg);
    send_frame(fr, 1'b1);                                   // samples must read back as zero
  endtask

  // Result side stalls for a long stretch while short frames keep coming back to back,
  // so the result register fills and input stalls; then the sender waits for the drain.
  task automatic test_backpressure();
    byte_q_t fr;
    steady = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (12) begin
      fr = make_frame(1, sof1_reg, sof2_reg, ($urandom_range(0, 3) == 0) ? ~tag_reg : tag_reg);
      send_frame(fr, 1'($urandom));
    end
    steady = 1'b0;
    wait_results_drained();
  endtask

  // Register extremes and random settings, each followed by random traffic
  task automatic test_register_sweep();
    program_registers(8'd0, 8'd0, 8'd255, 8'd0);
    test_random_traffic(100, 1);
    program_registers(8'd255, 8'd255, 8'd0, 8'd255);
    repeat (256) send_tick();                               // saturate the tick counter
    test_random_traffic(100, 1);
    repeat (2) begin
      program_registers(8'($urandom_range(0, 6)), 8'($urandom), 8'($urandom), 8'($urandom));
      test_random_traffic(100, 1);
    end
    program_registers(DEF_PERIOD, DEF_SOF1, DEF_SOF2, DEF_TAG);
    test_random_traffic(150, 2);
  endtask

  initial begin : run
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_BYTE;
    in_ch.data_byte   = 8'h00;
    in_ch.last_byte   = 1'b0;
    in_ch.tx_accepted = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PERIOD_TICKS;
    cfg_ch.data       = 8'h00;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_status_codes();
    test_line_error();
    test_random_traffic(400, 6);
    test_backpressure();
    test_register_sweep();

    wait_results_drained();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== imu_frame_checker_rate_limiter_core.f =====
rtl/imufc_pkg.sv
rtl/imufc_if.sv
rtl/imufc_capture.sv
rtl/imu_frame_checker_rate_limiter_core.sv
test/testbench.sv
